FILE: hw/rtl/arlm_pkg.sv
// Shared types, constants and helpers of the AT response line matcher.
package arlm_pkg;

   localparam int LINE_BYTES_DEFAULT    = 512;
   localparam int PATTERN_COUNT_DEFAULT = 8;
   localparam int PATTERN_BYTES_DEFAULT = 32;
   localparam int QUEUE_DEPTH           = 2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   localparam logic [7:0] CHAR_WILDCARD = 8'h1B;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_PROMPT   = 8'h3E;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_A        = 8'h41;
   localparam logic [7:0] CHAR_T        = 8'h54;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;

   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_TICK    = 2'd1,
      OP_READ    = 2'd2,
      OP_PATTERN = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LREAD,
      ST_ECHO_RD,
      ST_ECHO_CMP,
      ST_PAT_RD,
      ST_PAT_CMP,
      ST_REPORT
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data_byte;
      logic [2:0]  pattern_index;
      logic [8:0]  position;
      logic [5:0]  pattern_length;
      logic        pattern_ok;
      logic        pattern_pos_ok;
   } item_type;

   function automatic logic [7:0] echo_char(input logic [1:0] k);
      logic [7:0] c;
      case (k)
         2'd0: c = CHAR_A;
         2'd1: c = CHAR_T;
         2'd2: c = CHAR_PLUS;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: hw/rtl/at_response_line_matcher.sv
// Top level of the AT response line matcher.
// Items enter through a two-entry queue and busy rises only while that queue is full.
// A received byte, a tick or a pattern write is handled in the idle state of the back
// part; a line byte read also passes through ST_LREAD, and its result comes from a
// registered line store read and the registered outputs. A completed line is first
// checked for the "AT+" echo, which is reported at once; any other line is scanned over
// every pattern, stepping past each disabled one and comparing each enabled one byte by
// byte in a read and a compare state, then reported. Every compare step waits on one
// registered read of the single-port line store and pattern store.
// Each result is shown for exactly one cycle with rsp_strobe high and must be taken
// then, since the receiver cannot stall the block.
module at_response_line_matcher
   import arlm_pkg::*;
#(
   parameter int LINE_BYTES    = LINE_BYTES_DEFAULT,
   parameter int PATTERN_COUNT = PATTERN_COUNT_DEFAULT,
   parameter int PATTERN_BYTES = PATTERN_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_data_byte,
   input  logic [2:0]  req_pattern_index,
   input  logic [8:0]  req_position,
   input  logic [5:0]  req_pattern_length,
   output logic        rsp_strobe,
   output logic        rsp_kind,
   output logic [7:0]  rsp_match_mask,
   output logic        rsp_is_echo,
   output logic        rsp_is_prompt,
   output logic [8:0]  rsp_line_length,
   output logic [7:0]  rsp_read_byte,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic     q_full, q_empty, q_push, q_pop;
   item_type push_item, pop_item;

   arlm_front #(
      .PATTERN_COUNT(PATTERN_COUNT),
      .PATTERN_BYTES(PATTERN_BYTES)
   ) u_front (
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_data_byte      (req_data_byte),
      .req_pattern_index  (req_pattern_index),
      .req_position       (req_position),
      .req_pattern_length (req_pattern_length),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_item             (push_item)
   );

   arlm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .empty     (q_empty),
      .full      (q_full)
   );

   arlm_back #(
      .LINE_BYTES    (LINE_BYTES),
      .PATTERN_COUNT (PATTERN_COUNT),
      .PATTERN_BYTES (PATTERN_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_empty          (q_empty),
      .q_item           (pop_item),
      .q_pop            (q_pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_match_mask   (rsp_match_mask),
      .rsp_is_echo      (rsp_is_echo),
      .rsp_is_prompt    (rsp_is_prompt),
      .rsp_line_length  (rsp_line_length),
      .rsp_read_byte    (rsp_read_byte)
   );

endmodule

FILE: hw/rtl/arlm_front.sv
// Front part: accepts items and classifies them for the back part.
module arlm_front
   import arlm_pkg::*;
#(
   parameter int PATTERN_COUNT = PATTERN_COUNT_DEFAULT,
   parameter int PATTERN_BYTES = PATTERN_BYTES_DEFAULT
) (
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_func,
   input  logic [7:0] req_data_byte,
   input  logic [2:0] req_pattern_index,
   input  logic [8:0] req_position,
   input  logic [5:0] req_pattern_length,
   input  logic       q_full,
   output logic       q_push,
   output item_type   q_item
);

   assign busy   = q_full;
   assign q_push = start && !q_full;

   always_comb begin
      q_item.op             = op_type'(req_func);
      q_item.data_byte      = req_data_byte;
      q_item.pattern_index  = req_pattern_index;
      q_item.position       = req_position;
      q_item.pattern_ok     = int'(req_pattern_index) < PATTERN_COUNT;
      q_item.pattern_pos_ok = int'(req_position) < PATTERN_BYTES;
      if (int'(req_pattern_length) > PATTERN_BYTES) begin
         q_item.pattern_length = 6'(PATTERN_BYTES);
      end else begin
         q_item.pattern_length = req_pattern_length;
      end
   end

endmodule

FILE: hw/rtl/arlm_queue.sv
// Short item queue between the front and back parts.
module arlm_queue
   import arlm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty,
   output logic     full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type               entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]         count_ff, count_in;

   assign empty    = count_ff == '0;
   assign full     = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hw/rtl/arlm_back.sv
// Back part: line assembly, line store, pattern store and prefix matching.
module arlm_back
   import arlm_pkg::*;
#(
   parameter int LINE_BYTES    = LINE_BYTES_DEFAULT,
   parameter int PATTERN_COUNT = PATTERN_COUNT_DEFAULT,
   parameter int PATTERN_BYTES = PATTERN_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        q_empty,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_strobe,
   output logic        rsp_kind,
   output logic [7:0]  rsp_match_mask,
   output logic        rsp_is_echo,
   output logic        rsp_is_prompt,
   output logic [8:0]  rsp_line_length,
   output logic [7:0]  rsp_read_byte
);

   localparam int LA_W  = $clog2(LINE_BYTES);
   localparam int PA_W  = $clog2(PATTERN_COUNT * PATTERN_BYTES);
   localparam int PI_W  = $clog2(PATTERN_COUNT + 1);
   localparam int PK_W  = $clog2(PATTERN_BYTES);
   localparam int PL_W  = $clog2(PATTERN_BYTES + 1);
   localparam int CMP_W = (LA_W > 9 ? LA_W : 9) + 1;

   state_type        state_ff, state_in;
   logic [LA_W-1:0]  fill_ff, fill_in;
   logic [LA_W-1:0]  start_ff, start_in;
   logic             active_ff, active_in;
   logic [15:0]      elapsed_ff, elapsed_in;
   logic [15:0]      timeout_ff;
   logic [PL_W-1:0]  plen_ff [PATTERN_COUNT];
   logic [7:0]       last_byte_ff, last_byte_in;
   logic [PI_W-1:0]  pidx_ff, pidx_in;
   logic [PK_W-1:0]  k_ff, k_in;
   logic             beyond_ff, beyond_in;
   logic [7:0]       mask_ff, mask_in;
   logic             echo_ff, echo_in;
   logic             prompt_ff, prompt_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic             rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_mask_ff, rsp_mask_in;
   logic             rsp_echo_ff, rsp_echo_in;
   logic             rsp_prompt_ff, rsp_prompt_in;
   logic [8:0]       rsp_len_ff, rsp_len_in;
   logic [7:0]       rsp_read_ff, rsp_read_in;

   logic [7:0]       line_mem [LINE_BYTES];
   logic [7:0]       pat_mem [PATTERN_COUNT * PATTERN_BYTES];
   logic [7:0]       ldata_ff;
   logic [7:0]       pdata_ff;

   logic             have_item;
   logic [LA_W-1:0]  fill_eff, start_eff, start_next;
   logic [LA_W-1:0]  line_base, line_off, line_addr;
   logic [LA_W:0]    line_sum;
   logic             line_we, pat_we, plen_we;
   logic [PA_W-1:0]  pat_addr;
   logic             prompt_case, crlf_case, fetch_beyond;
   logic [PL_W-1:0]  cur_len;
   logic [7:0]       line_byte;
   logic             pat_mismatch, pat_last, pat_done;
   logic [15:0]      elapsed_sat;
   logic [CMP_W-1:0] fill_wide;

   assign have_item   = !q_empty;
   assign fill_eff    = active_ff ? fill_ff : '0;
   assign start_eff   = active_ff ? start_ff : '0;
   assign start_next  = (start_eff == LA_W'(LINE_BYTES-1)) ? '0 : start_eff + LA_W'(1);
   assign prompt_case = (fill_eff == LA_W'(1)) && (q_item.data_byte == CHAR_SPACE) &&
                        (last_byte_ff == CHAR_PROMPT);
   assign crlf_case   = (fill_eff != '0) && (q_item.data_byte == CHAR_LF) &&
                        (last_byte_ff == CHAR_CR);
   assign line_byte   = beyond_ff ? 8'h00 : ldata_ff;
   assign pat_mismatch = (pdata_ff != CHAR_WILDCARD) && (line_byte != pdata_ff);
   assign pat_last    = (CMP_W'(k_ff) + CMP_W'(1)) == CMP_W'(cur_len);
   assign pat_done    = CMP_W'(pidx_ff) >= CMP_W'(PATTERN_COUNT);
   assign elapsed_sat = (elapsed_ff != 16'hFFFF) ? elapsed_ff + 16'd1 : elapsed_ff;
   assign fill_wide   = CMP_W'(fill_ff);

   always_comb begin
      cur_len = '0;
      for (int j = 0; j < PATTERN_COUNT; j++) begin
         if (CMP_W'(pidx_ff) == CMP_W'(j)) begin
            cur_len = plen_ff[j];
         end
      end
   end

   always_comb begin
      if (state_ff == ST_IDLE) begin
         if (q_item.op == OP_READ) begin
            line_base    = start_ff;
            line_off     = LA_W'(q_item.position);
            fetch_beyond = CMP_W'(q_item.position) >= fill_wide;
         end else begin
            line_base    = start_eff;
            line_off     = fill_eff;
            fetch_beyond = 1'b0;
         end
         pat_addr = PA_W'(PA_W'(q_item.pattern_index) * PA_W'(PATTERN_BYTES)) +
                    PA_W'(q_item.position);
      end else begin
         line_base    = start_ff;
         line_off     = LA_W'(k_ff);
         fetch_beyond = CMP_W'(k_ff) >= fill_wide;
         pat_addr     = PA_W'(PA_W'(pidx_ff) * PA_W'(PATTERN_BYTES)) + PA_W'(k_ff);
      end
      line_sum = {1'b0, line_base} + {1'b0, line_off};
      if (line_sum >= (LA_W+1)'(LINE_BYTES)) begin
         line_addr = LA_W'(line_sum - (LA_W+1)'(LINE_BYTES));
      end else begin
         line_addr = line_sum[LA_W-1:0];
      end
   end

   assign q_pop   = (state_ff == ST_IDLE) && have_item;
   assign line_we = q_pop && (q_item.op == OP_BYTE) && !crlf_case;
   assign plen_we = q_pop && (q_item.op == OP_PATTERN) && q_item.pattern_ok;
   assign pat_we  = plen_we && q_item.pattern_pos_ok;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (have_item) begin
               case (q_item.op)
                  OP_BYTE: begin
                     if (prompt_case) begin
                        state_in = ST_ECHO_RD;
                     end else if (crlf_case && (fill_eff != LA_W'(1))) begin
                        state_in = ST_ECHO_RD;
                     end
                  end
                  OP_READ: state_in = ST_LREAD;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LREAD: state_in = ST_IDLE;
         ST_ECHO_RD: state_in = ST_ECHO_CMP;
         ST_ECHO_CMP: begin
            if (line_byte != echo_char(k_ff[1:0])) begin
               state_in = ST_PAT_RD;
            end else if (k_ff == PK_W'(2)) begin
               state_in = ST_REPORT;
            end else begin
               state_in = ST_ECHO_RD;
            end
         end
         ST_PAT_RD: begin
            if (pat_done) begin
               state_in = ST_REPORT;
            end else if (cur_len != '0) begin
               state_in = ST_PAT_CMP;
            end
         end
         ST_PAT_CMP: state_in = ST_PAT_RD;
         ST_REPORT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      fill_in       = fill_ff;
      start_in      = start_ff;
      active_in     = active_ff;
      elapsed_in    = elapsed_ff;
      last_byte_in  = last_byte_ff;
      pidx_in       = pidx_ff;
      k_in          = k_ff;
      beyond_in     = beyond_ff;
      mask_in       = mask_ff;
      echo_in       = echo_ff;
      prompt_in     = prompt_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_echo_in   = rsp_echo_ff;
      rsp_prompt_in = rsp_prompt_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_read_in   = rsp_read_ff;
      case (state_ff)
         ST_IDLE: begin
            if (have_item) begin
               case (q_item.op)
                  OP_BYTE: begin
                     if (!active_ff) begin
                        elapsed_in = '0;
                     end
                     start_in  = start_eff;
                     k_in      = '0;
                     mask_in   = '0;
                     echo_in   = 1'b0;
                     prompt_in = 1'b0;
                     if (prompt_case) begin
                        fill_in   = LA_W'(2);
                        active_in = 1'b0;
                        prompt_in = 1'b1;
                     end else if (crlf_case) begin
                        fill_in   = fill_eff - LA_W'(1);
                        active_in = 1'b0;
                     end else begin
                        active_in    = 1'b1;
                        last_byte_in = q_item.data_byte;
                        if (fill_eff >= LA_W'(LINE_BYTES-1)) begin
                           start_in = start_next;
                           fill_in  = fill_eff;
                        end else begin
                           fill_in = fill_eff + LA_W'(1);
                        end
                     end
                  end
                  OP_TICK: begin
                     if (active_ff) begin
                        elapsed_in = elapsed_sat;
                        if (elapsed_sat >= timeout_ff) begin
                           active_in = 1'b0;
                           fill_in   = '0;
                        end
                     end
                  end
                  OP_READ: beyond_in = fetch_beyond;
                  default: beyond_in = beyond_ff;
               endcase
            end
         end
         ST_LREAD: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = 1'b1;
            rsp_mask_in   = '0;
            rsp_echo_in   = 1'b0;
            rsp_prompt_in = 1'b0;
            rsp_len_in    = '0;
            rsp_read_in   = line_byte;
         end
         ST_ECHO_RD: beyond_in = fetch_beyond;
         ST_ECHO_CMP: begin
            if (line_byte != echo_char(k_ff[1:0])) begin
               pidx_in = '0;
               k_in    = '0;
            end else if (k_ff == PK_W'(2)) begin
               echo_in = 1'b1;
            end else begin
               k_in = k_ff + PK_W'(1);
            end
         end
         ST_PAT_RD: begin
            if (!pat_done) begin
               if (cur_len == '0) begin
                  pidx_in = pidx_ff + PI_W'(1);
               end else begin
                  beyond_in = fetch_beyond;
               end
            end
         end
         ST_PAT_CMP: begin
            if (pat_mismatch) begin
               pidx_in = pidx_ff + PI_W'(1);
               k_in    = '0;
            end else if (pat_last) begin
               mask_in = mask_ff | (8'(1) << pidx_ff);
               pidx_in = pidx_ff + PI_W'(1);
               k_in    = '0;
            end else begin
               k_in = k_ff + PK_W'(1);
            end
         end
         ST_REPORT: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = 1'b0;
            rsp_mask_in   = mask_ff;
            rsp_echo_in   = echo_ff;
            rsp_prompt_in = prompt_ff;
            rsp_len_in    = fill_wide[8:0];
            rsp_read_in   = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         start_ff      <= '0;
         active_ff     <= 1'b0;
         elapsed_ff    <= '0;
         timeout_ff    <= TIMEOUT_RESET;
         rsp_strobe_ff <= 1'b0;
         for (int j = 0; j < PATTERN_COUNT; j++) begin
            plen_ff[j] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         start_ff      <= start_in;
         active_ff     <= active_in;
         elapsed_ff    <= elapsed_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            timeout_ff <= csr_write_data;
         end
         for (int j = 0; j < PATTERN_COUNT; j++) begin
            if (plen_we && (int'(q_item.pattern_index) == j)) begin
               plen_ff[j] <= PL_W'(q_item.pattern_length);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      last_byte_ff  <= last_byte_in;
      pidx_ff       <= pidx_in;
      k_ff          <= k_in;
      beyond_ff     <= beyond_in;
      mask_ff       <= mask_in;
      echo_ff       <= echo_in;
      prompt_ff     <= prompt_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_echo_ff   <= rsp_echo_in;
      rsp_prompt_ff <= rsp_prompt_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_read_ff   <= rsp_read_in;
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_addr] <= q_item.data_byte;
      end
      ldata_ff <= line_mem[line_addr];
   end

   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[pat_addr] <= q_item.data_byte;
      end
      pdata_ff <= pat_mem[pat_addr];
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_match_mask  = rsp_mask_ff;
   assign rsp_is_echo     = rsp_echo_ff;
   assign rsp_is_prompt   = rsp_prompt_ff;
   assign rsp_line_length = rsp_len_ff;
   assign rsp_read_byte   = rsp_read_ff;

endmodule
